// ===== rtl/core/hpal_pkg.sv =====
package hpal_pkg;

    localparam int DepthBins = 16384;
    localparam int BinAw     = 14;
    localparam int BinW      = 20;
    localparam int SkipLog2  = 2;

    localparam logic [1:0] CmdSample = 2'd0;
    localparam logic [1:0] CmdBounds = 2'd1;
    localparam logic [1:0] CmdLevel  = 2'd2;

    localparam logic [1:0] CfgWidth  = 2'd0;
    localparam logic [1:0] CfgHeight = 2'd1;
    localparam logic [1:0] CfgDepth  = 2'd2;
    localparam logic [1:0] CfgBright = 2'd3;

    // divider request / response
    typedef struct packed {
        logic        go;
        logic [47:0] num;
        logic [47:0] den;
    } t_div_req;

    typedef struct packed {
        logic        done;
        logic [47:0] quo;
    } t_div_rsp;

endpackage

// ===== rtl/core/hpal_hist_ram.sv =====
module hpal_hist_ram import hpal_pkg::*; (
    input  logic                 i_clk,
    input  logic                 i_we,
    input  logic [BinAw-1:0]     i_waddr,
    input  logic [BinW-1:0]      i_wdata,
    input  logic [BinAw-1:0]     i_raddr,
    output logic [BinW-1:0]      o_rdata
);

    logic [BinW-1:0] r_mem [DepthBins];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

// ===== rtl/core/hpal_div.sv =====
// restoring divider, one quotient bit per cycle
module hpal_div import hpal_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    logic [47:0] r_quo;
    logic [48:0] r_rem;
    logic [47:0] r_den;
    logic [5:0]  r_cnt;
    logic        r_run;
    logic        r_done;
    logic [48:0] w_trial;

    assign w_trial    = {r_rem[47:0], r_quo[47]};
    assign o_rsp.done = r_done;
    assign o_rsp.quo  = r_quo;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run  <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_req.go) begin
                r_run <= 1'b1;
                r_cnt <= 6'd47;
                r_quo <= i_req.num;
                r_den <= i_req.den;
                r_rem <= '0;
            end else if (r_run) begin
                if (w_trial >= {1'b0, r_den}) begin
                    r_rem <= w_trial - {1'b0, r_den};
                    r_quo <= {r_quo[46:0], 1'b1};
                end else begin
                    r_rem <= w_trial;
                    r_quo <= {r_quo[46:0], 1'b0};
                end
                if (r_cnt == 6'd0) begin
                    r_run  <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 6'd1;
                end
            end
        end
    end

endmodule

// ===== rtl/core/histogram_percentile_auto_level_unit.sv =====
// Sample item: accept, read and write when counted; only the accept when dropped.
// Level item: waits on the 48-step shared divider; strobe when it is done.
// Bounds item: walks bins from each end, then the span and brightness steps, plus a
//   divider pass when brightness is 1..255; each walk covers at most D = min(pixel_depth, 16384) bins.
// The clear after a bounds item sweeps all 16384 bins; reset starts the same sweep.
// Result strobe lasts one cycle; the receiver cannot stall, busy gates every item.
module histogram_percentile_auto_level_unit import hpal_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               start,
    output logic               busy,
    input  logic [1:0]         i_command,
    input  logic [15:0]        i_pixel,
    input  logic [11:0]        i_row,
    input  logic [11:0]        i_col,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [15:0]        i_cfg_data,
    output logic               o_valid,
    output logic               o_kind,
    output logic [7:0]         o_level,
    output logic signed [20:0] o_display_low,
    output logic [23:0]        o_display_span
);

    typedef enum logic [4:0] {
        S_INIT, S_IDLE, S_SRD, S_SWR,
        S_LVL_DIV, S_LVL_WAIT,
        S_LO_RD, S_LO_ACC, S_HI_RD, S_HI_ACC,
        S_SPAN, S_SPAN_DIV, S_SPAN_MUL, S_BRT, S_BRT_WAIT, S_REPORT, S_CLR
    } t_state;

    t_state r_state;

    // config registers
    logic [12:0] r_width, r_height;
    logic [14:0] r_depth;
    logic [15:0] r_bright;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= 13'd4096;
            r_height <= 13'd4096;
            r_depth  <= 15'd16384;
            r_bright <= 16'd256;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CfgWidth:  r_width  <= i_cfg_data[12:0];
                CfgHeight: r_height <= i_cfg_data[12:0];
                CfgDepth:  r_depth  <= i_cfg_data[14:0];
                CfgBright: r_bright <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // effective depth, 15 bits so 16384 fits
    logic [14:0] w_deff;
    assign w_deff = (r_depth < 15'(DepthBins)) ? r_depth : 15'(DepthBins);

    // percentile count: width*height/16
    logic [25:0] w_area;
    logic [21:0] w_npix;
    assign w_area = 26'(r_width) * 26'(r_height);
    assign w_npix = w_area[25:4];

    // histogram memory
    logic             w_we;
    logic [BinAw-1:0] w_waddr, w_raddr;
    logic [BinW-1:0]  w_wdata, w_rdata;

    hpal_hist_ram u_ram (
        .i_clk  (i_clk),
        .i_we   (w_we),
        .i_waddr(w_waddr),
        .i_wdata(w_wdata),
        .i_raddr(w_raddr),
        .o_rdata(w_rdata)
    );

    // shared divider
    t_div_req r_req;
    t_div_rsp w_rsp;

    hpal_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (r_req),
        .o_rsp  (w_rsp)
    );

    logic [15:0]        r_pix;
    logic [14:0]        r_ptr;      // bin walk pointer, also clear index
    logic [29:0]        r_sum;      // sum of up to 16384 20-bit bins
    logic signed [16:0] r_lo, r_hi;
    logic signed [33:0] r_lq;       // Q.8 low bound
    logic [33:0]        r_sq;       // Q.8 span
    logic [25:0]        r_snum;     // diff*3328, span before the divide by 10
    logic [40:0]        r_prod;
    logic               r_lvl_pos;

    // walk condition: sum*100 < npix
    logic [36:0] w_sum100;
    logic        w_walk;
    assign w_sum100 = 37'({r_sum, 6'd0}) + 37'({r_sum, 5'd0}) + 37'({r_sum, 2'd0});
    assign w_walk   = w_sum100 < {15'd0, w_npix};

    // divide by 10 as a reciprocal multiply, exact for numerators below 2^32
    logic [57:0] w_div10;
    assign w_div10 = 58'(r_snum) * 58'(32'hCCCC_CCCD);

    logic w_sample_ok;
    assign w_sample_ok = (i_row[SkipLog2-1:0] == '0) && (i_col[SkipLog2-1:0] == '0)
                      && ({1'b0, i_row} < r_height) && ({1'b0, i_col} < r_width)
                      && (i_pixel < {1'b0, w_deff});

    // level numerator (p*256 - low)*255, sign checked before the divide
    logic signed [35:0] w_diffp;
    assign w_diffp = $signed({12'd0, r_pix, 8'd0}) - 36'(r_lq);

    // sample read is issued at accept and held through S_SRD
    assign w_raddr = (r_state == S_IDLE) ? i_pixel[BinAw-1:0] :
                     (r_state == S_SRD)  ? r_pix[BinAw-1:0]   : r_ptr[BinAw-1:0];
    assign w_we    = (r_state == S_SWR) || (r_state == S_CLR) || (r_state == S_INIT);
    assign w_waddr = (r_state == S_SWR) ? r_pix[BinAw-1:0] : r_ptr[BinAw-1:0];
    assign w_wdata = (r_state == S_SWR) ? ((&w_rdata) ? w_rdata : w_rdata + 20'd1) : '0;

    assign busy = (r_state != S_IDLE);

    logic signed [17:0] w_hi2, w_lo2;
    assign w_hi2 = 18'(r_hi) + 18'sd2;   // final bounds with the outward margins
    assign w_lo2 = 18'(r_lo) - 18'sd2;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_INIT;
            r_ptr   <= '0;
            r_lq    <= '0;
            r_sq    <= '0;
            o_valid <= 1'b0;
            r_req.go <= 1'b0;
        end else begin
            o_valid  <= 1'b0;
            r_req.go <= 1'b0;
            unique case (r_state)
                S_INIT: begin
                    r_ptr <= r_ptr + 15'd1;
                    if (r_ptr == 15'(DepthBins - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_pix <= i_pixel;
                    if (start) begin
                        unique case (i_command)
                            CmdSample: if (w_sample_ok) r_state <= S_SRD;
                            CmdBounds: begin
                                r_ptr   <= '0;
                                r_sum   <= '0;
                                r_state <= S_LO_RD;
                            end
                            CmdLevel: r_state <= S_LVL_DIV;
                            default: ;
                        endcase
                    end
                end
                S_SRD: r_state <= S_SWR;
                S_SWR: r_state <= S_IDLE;
                S_LVL_DIV: begin
                    r_lvl_pos <= (r_sq != '0) && (w_diffp > 0);
                    r_req.go  <= 1'b1;
                    r_req.num <= 48'(w_diffp) * 48'd255;
                    r_req.den <= (r_sq == '0) ? 48'd1 : 48'(r_sq);
                    r_state   <= S_LVL_WAIT;
                end
                S_LVL_WAIT: if (w_rsp.done) begin
                    o_valid        <= 1'b1;
                    o_kind         <= 1'b0;
                    o_display_low  <= '0;
                    o_display_span <= '0;
                    o_level <= !r_lvl_pos ? 8'd0 :
                               (w_rsp.quo > 48'd255) ? 8'd255 : w_rsp.quo[7:0];
                    r_state <= S_IDLE;
                end
                // lower walk: read lands in the cycle after the address
                S_LO_RD: begin
                    if (w_walk && r_ptr < w_deff) begin
                        r_state <= S_LO_ACC;
                    end else begin
                        r_lo    <= 17'(r_ptr);
                        r_hi    <= 17'(w_deff) - 17'sd1;
                        r_ptr   <= w_deff - 15'd1;
                        r_sum   <= '0;
                        r_state <= S_HI_RD;
                    end
                end
                S_LO_ACC: begin
                    r_sum   <= r_sum + 30'(w_rdata);
                    r_ptr   <= r_ptr + 15'd1;
                    r_state <= S_LO_RD;
                end
                // upper walk; r_hi is the signed bin index, r_ptr its address
                S_HI_RD: begin
                    if (w_walk && !r_hi[16]) begin
                        r_state <= S_HI_ACC;
                    end else begin
                        r_state <= S_SPAN;
                    end
                end
                S_HI_ACC: begin
                    r_sum   <= r_sum + 30'(w_rdata);
                    r_hi    <= r_hi - 17'sd1;
                    r_ptr   <= r_ptr - 15'd1;
                    r_state <= S_HI_RD;
                end
                S_SPAN: begin
                    // empty window falls back to 0..depth
                    if (w_hi2 <= w_lo2) begin
                        r_lq   <= '0;
                        r_snum <= 26'(w_deff) * 26'd3328;
                    end else begin
                        r_lq   <= 34'(w_lo2) <<< 8;
                        r_snum <= 26'(w_hi2 - w_lo2) * 26'd3328;
                    end
                    r_state <= S_SPAN_DIV;
                end
                S_SPAN_DIV: begin
                    r_sq    <= 34'(w_div10[57:35]);
                    r_state <= S_SPAN_MUL;
                end
                S_SPAN_MUL: begin
                    r_prod  <= 41'(r_sq[24:0]) * 41'(r_bright);
                    r_state <= S_BRT;
                end
                S_BRT: begin
                    if (r_bright > 16'd256) begin
                        r_lq    <= r_lq + $signed(r_sq) - $signed(34'(r_prod >> 8));
                        r_sq    <= 34'(r_prod >> 8);
                        r_state <= S_REPORT;
                    end else if (r_bright != 16'd0 && r_bright < 16'd256) begin
                        r_req.go  <= 1'b1;
                        r_req.num <= 48'(r_sq) << 8;
                        r_req.den <= 48'(r_bright);
                        r_state   <= S_BRT_WAIT;
                    end else begin
                        r_state <= S_REPORT;
                    end
                end
                S_BRT_WAIT: if (w_rsp.done) begin
                    r_sq    <= w_rsp.quo[33:0];
                    r_state <= S_REPORT;
                end
                S_REPORT: begin
                    o_valid <= 1'b1;
                    o_kind  <= 1'b1;
                    o_level <= '0;
                    if ((r_lq >>> 8) < -34'sd1048576) o_display_low <= 21'h100000;
                    else if ((r_lq >>> 8) > 34'sd65535) o_display_low <= 21'd65535;
                    else o_display_low <= 21'(r_lq >>> 8);
                    o_display_span <= (r_sq[33:8] > 26'd16777215) ? 24'hFFFFFF
                                                                   : r_sq[31:8];
                    r_ptr   <= '0;
                    r_state <= S_CLR;
                end
                // every bin, as the depth may have shrunk since samples went in
                S_CLR: begin
                    r_ptr <= r_ptr + 15'd1;
                    if (r_ptr == 15'(DepthBins - 1)) r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

endmodule
